### rtl/core/debf_pkg.sv
// shared widths, constants and handoff types of the disparity energy band finder
`default_nettype none

package debf_pkg;

   // field and register widths
   localparam int DISP_W     = 16;
   localparam int ROW_E_W    = 26;
   localparam int TOT_W      = 36;
   localparam int RATIO_W    = 16;
   localparam int FRAC_W     = 16;
   localparam int NROWS_W    = 11;
   localparam int START_W    = 10;
   localparam int HEIGHT_W   = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // saturation limits of the row and frame sums
   localparam logic [ROW_E_W-1:0] ROW_E_MAX = '1;
   localparam logic [TOT_W-1:0]   TOT_MAX   = '1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_ROWS     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENERGY_RATIO = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MARGIN_RATIO = 2'd2;

   // register reset values
   localparam logic [NROWS_W-1:0] NUM_ROWS_RST     = 11'd480;
   localparam logic [RATIO_W-1:0] ENERGY_RATIO_RST = 16'd52429;
   localparam logic [RATIO_W-1:0] MARGIN_RATIO_RST = 16'd6554;

   // x/5 as (x * 52429) >> 18, exact for x below 2^16
   localparam int                 DIV5_W     = 17;
   localparam logic [DIV5_W-1:0]  DIV5_RECIP = 17'd52429;
   localparam int                 DIV5_SHIFT = 18;

   // finished frame handed from front to back
   typedef struct packed {
      logic             bank;
      logic [TOT_W-1:0] total;
   } job_type;

   // back end hands a store bank back to the front
   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

endpackage

`default_nettype wire

### rtl/core/disparity_energy_band_finder.sv
// top level of the disparity energy band finder: registers, front, queue and back end
`default_nettype none

// Pixels are taken one per clock while the store bank being filled is free. The row
// store has two banks of MAX_ROWS entries: the front fills one bank while the back
// searches the other, so a frame's search overlaps the next frame's pixels. The search
// adds a frame's rows one at a time and drops top rows while the rest still reaches the
// target, one store read per pointer per cycle; the back also takes the frame, forms
// the target and margin, and widens, clamps and re-centers the band. A frame with zero
// energy skips the search. Pixels stall (full high) when a frame ends while the bank for
// the next frame is still held by the earlier frame, queued or being searched, or by that
// frame's result waiting for the result register to be popped. One result comes per
// frame, after the pixel that ends its last row. No clearing pass is needed after reset.
module disparity_energy_band_finder #(
   parameter int MAX_ROWS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic signed [debf_pkg::DISP_W-1:0]  req_disparity,
   input  wire logic                                req_row_end,
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [debf_pkg::START_W-1:0]             rsp_band_start,
   output logic [debf_pkg::HEIGHT_W-1:0]            rsp_band_height,
   input  wire logic                                csr_write_en,
   input  wire logic [debf_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  wire logic [debf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import debf_pkg::*;

   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int RIW = $clog2(MAX_ROWS);
   localparam int EXW = (RW > NROWS_W) ? RW : NROWS_W;

   logic [NROWS_W-1:0] num_rows_ff, num_rows_in;
   logic [RATIO_W-1:0] energy_ratio_ff, energy_ratio_in;
   logic [RATIO_W-1:0] margin_ratio_ff, margin_ratio_in;

   logic [EXW-1:0]     nr_ext;
   logic [EXW-1:0]     max_ext;
   logic [EXW-1:0]     eff_ext;
   logic [RW-1:0]      rows;

   logic               job_push;
   job_type            push_job;
   logic               job_pop;
   logic               head_valid;
   job_type            head_job;
   rel_type            rel;
   logic               mem_we;
   logic [RIW:0]       mem_waddr;
   logic [ROW_E_W-1:0] mem_wdata;

   // configuration registers
   always_comb begin
      num_rows_in     = num_rows_ff;
      energy_ratio_in = energy_ratio_ff;
      margin_ratio_in = margin_ratio_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_NUM_ROWS:     num_rows_in     = csr_wdata[NROWS_W-1:0];
            CSR_ENERGY_RATIO: energy_ratio_in = csr_wdata[RATIO_W-1:0];
            CSR_MARGIN_RATIO: margin_ratio_in = csr_wdata[RATIO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff     <= NUM_ROWS_RST;
         energy_ratio_ff <= ENERGY_RATIO_RST;
         margin_ratio_ff <= MARGIN_RATIO_RST;
      end else begin
         num_rows_ff     <= num_rows_in;
         energy_ratio_ff <= energy_ratio_in;
         margin_ratio_ff <= margin_ratio_in;
      end
   end

   // row count clamped to 1..MAX_ROWS
   assign nr_ext  = EXW'(num_rows_ff);
   assign max_ext = EXW'(MAX_ROWS);
   assign eff_ext = (nr_ext == '0) ? EXW'(1) : ((nr_ext > max_ext) ? max_ext : nr_ext);
   assign rows    = RW'(eff_ext);

   debf_front #(
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .rows      (rows),
      .push      (push),
      .disparity (req_disparity),
      .row_end   (req_row_end),
      .full      (full),
      .rel       (rel),
      .job_push  (job_push),
      .job       (push_job),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata)
   );

   debf_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   debf_back #(
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .rows         (rows),
      .energy_ratio (energy_ratio_ff),
      .margin_ratio (margin_ratio_ff),
      .job_valid    (head_valid),
      .job          (head_job),
      .job_pop      (job_pop),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .rel          (rel),
      .pop          (pop),
      .empty        (empty),
      .band_start   (rsp_band_start),
      .band_height  (rsp_band_height)
   );

endmodule

`default_nettype wire

### rtl/core/debf_front.sv
// front end: per-row energy sums, frame total, row store writes and frame handoff
`default_nettype none

module debf_front #(
   parameter int MAX_ROWS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [$clog2(MAX_ROWS+1)-1:0]       rows,
   input  wire logic                                push,
   input  wire logic signed [debf_pkg::DISP_W-1:0]  disparity,
   input  wire logic                                row_end,
   output logic                                     full,
   input  wire debf_pkg::rel_type                   rel,
   output logic                                     job_push,
   output debf_pkg::job_type                        job,
   output logic                                     mem_we,
   output logic [$clog2(MAX_ROWS):0]                mem_waddr,
   output logic [debf_pkg::ROW_E_W-1:0]             mem_wdata
);
   import debf_pkg::*;

   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int RIW = $clog2(MAX_ROWS);

   logic                accept;
   logic                pos;
   logic [ROW_E_W:0]    acc_sum;
   logic [ROW_E_W-1:0]  acc_new;
   logic                frame_last;
   logic [TOT_W:0]      tot_sum;
   logic [TOT_W-1:0]    tot_sat;

   logic [ROW_E_W-1:0]  acc_ff, acc_in;
   logic [RIW-1:0]      seen_ff, seen_in;
   logic                bank_ff, bank_in;
   logic [1:0]          busy_ff, busy_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic                row_vld_ff, row_vld_in;
   logic                row_last_ff, row_last_in;
   logic                row_bank_ff, row_bank_in;
   logic [RIW-1:0]      row_idx_ff, row_idx_in;
   logic [ROW_E_W-1:0]  row_word_ff, row_word_in;

   // a pixel waits while the bank it would fill is still held by an earlier frame
   assign full   = busy_ff[bank_ff];
   assign accept = push && !full;

   // positive pixels add to the row sum, saturating
   assign pos     = !disparity[DISP_W-1] && (disparity != '0);
   assign acc_sum = {1'b0, acc_ff} + (ROW_E_W+1)'(disparity[DISP_W-2:0]);
   assign acc_new = !pos ? acc_ff : (acc_sum[ROW_E_W] ? ROW_E_MAX : acc_sum[ROW_E_W-1:0]);

   assign frame_last = (RW'(seen_ff) + RW'(1)) >= rows;

   // frame total, saturating
   assign tot_sum = {1'b0, total_ff} + (TOT_W+1)'(row_word_ff);
   assign tot_sat = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];

   // row store write and frame handoff from the second stage
   assign mem_we    = row_vld_ff;
   assign mem_waddr = {row_bank_ff, row_idx_ff};
   assign mem_wdata = row_word_ff;
   assign job_push  = row_vld_ff && row_last_ff;
   assign job.bank  = row_bank_ff;
   assign job.total = tot_sat;

   // pixel stage
   always_comb begin
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      bank_in     = bank_ff;
      row_vld_in  = 1'b0;
      row_last_in = row_last_ff;
      row_bank_in = row_bank_ff;
      row_idx_in  = row_idx_ff;
      row_word_in = row_word_ff;
      if (accept) begin
         if (row_end) begin
            row_vld_in  = 1'b1;
            row_last_in = frame_last;
            row_bank_in = bank_ff;
            row_idx_in  = seen_ff;
            row_word_in = acc_new;
            acc_in      = '0;
            if (frame_last) begin
               seen_in = '0;
               bank_in = !bank_ff;
            end else begin
               seen_in = seen_ff + RIW'(1);
            end
         end else begin
            acc_in = acc_new;
         end
      end
   end

   // row stage and bank ownership
   always_comb begin
      total_in = total_ff;
      busy_in  = busy_ff;
      if (row_vld_ff) begin
         total_in = row_last_ff ? '0 : tot_sat;
      end
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (job_push) begin
         busy_in[row_bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         seen_ff    <= '0;
         bank_ff    <= 1'b0;
         busy_ff    <= '0;
         total_ff   <= '0;
         row_vld_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         seen_ff    <= seen_in;
         bank_ff    <= bank_in;
         busy_ff    <= busy_in;
         total_ff   <= total_in;
         row_vld_ff <= row_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      row_last_ff <= row_last_in;
      row_bank_ff <= row_bank_in;
      row_idx_ff  <= row_idx_in;
      row_word_ff <= row_word_in;
   end

endmodule

`default_nettype wire

### rtl/core/debf_job_queue.sv
// two-entry queue of finished frames between front and back end
`default_nettype none

module debf_job_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire debf_pkg::job_type push_job,
   input  wire logic              pop,
   output logic                   head_valid,
   output debf_pkg::job_type      head_job
);
   import debf_pkg::*;

   job_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head_valid = (cnt_ff != 2'd0);
   assign head_job   = ent_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/core/debf_back.sv
// back end: row store, target, two-pointer band search, margin and result register
`default_nettype none

module debf_back #(
   parameter int MAX_ROWS = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [$clog2(MAX_ROWS+1)-1:0]     rows,
   input  wire logic [debf_pkg::RATIO_W-1:0]      energy_ratio,
   input  wire logic [debf_pkg::RATIO_W-1:0]      margin_ratio,
   input  wire logic                              job_valid,
   input  wire debf_pkg::job_type                 job,
   output logic                                   job_pop,
   input  wire logic                              mem_we,
   input  wire logic [$clog2(MAX_ROWS):0]         mem_waddr,
   input  wire logic [debf_pkg::ROW_E_W-1:0]      mem_wdata,
   output debf_pkg::rel_type                      rel,
   input  wire logic                              pop,
   output logic                                   empty,
   output logic [debf_pkg::START_W-1:0]           band_start,
   output logic [debf_pkg::HEIGHT_W-1:0]          band_height
);
   import debf_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int DEPTH = 2 ** (RIW + 1);
   localparam int WSW   = ROW_E_W + RIW;
   localparam int CW    = (WSW > TOT_W) ? WSW : TOT_W;
   localparam int SW    = RW + 3;
   localparam int LO_W  = 18;
   localparam int PL_W  = LO_W + RATIO_W;
   localparam int PH_W  = TOT_W - LO_W + RATIO_W;
   localparam int MG_W  = RW + RATIO_W;
   localparam int D5_W  = RW + DIV5_W;

   localparam logic signed [SW-1:0] ONE_S  = SW'(1);
   localparam logic signed [SW-1:0] ZERO_S = SW'(0);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MUL  = 9'b000000010,
      S_TGT  = 9'b000000100,
      S_ADD  = 9'b000001000,
      S_SHR  = 9'b000010000,
      S_FIN1 = 9'b000100000,
      S_FIN2 = 9'b001000000,
      S_FIN3 = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   // row store, two banks
   logic [ROW_E_W-1:0] mem [DEPTH];
   logic [RIW:0]       raddr_a;
   logic [RIW:0]       raddr_b;
   logic [ROW_E_W-1:0] rd_a_ff;
   logic [ROW_E_W-1:0] rd_b_ff;

   state_type          state_ff, state_in;
   logic               bank_ff, bank_in;
   logic [TOT_W-1:0]   tot_ff, tot_in;
   logic [PH_W-1:0]    p_hi_ff, p_hi_in;
   logic [PL_W-1:0]    p_lo_ff, p_lo_in;
   logic [RW-1:0]      margin_ff, margin_in;
   logic [RW-1:0]      minh_ff, minh_in;
   logic [TOT_W-1:0]   target_ff, target_in;
   logic [WSW-1:0]     wsum_ff, wsum_in;
   logic [RW-1:0]      top_ff, top_in;
   logic [RW-1:0]      bottom_ff, bottom_in;
   logic [RW-1:0]      best_h_ff, best_h_in;
   logic [RW-1:0]      best_s_ff, best_s_in;
   logic signed [SW-1:0] ys_ff, ys_in;
   logic signed [SW-1:0] ye_ff, ye_in;
   logic signed [SW-1:0] ht_ff, ht_in;
   logic               short_ff, short_in;
   logic [START_W-1:0]  res_start_ff, res_start_in;
   logic [HEIGHT_W-1:0] res_height_ff, res_height_in;
   logic               out_valid_ff, out_valid_in;
   logic [START_W-1:0]  out_start_ff, out_start_in;
   logic [HEIGHT_W-1:0] out_height_ff, out_height_in;

   logic [MG_W-1:0]    mg_prod;
   logic [D5_W-1:0]    d5_prod;
   logic [RW-2:0]      fifth;
   logic               shrink;
   logic               reach;
   logic [RW-1:0]      win_h;
   logic [WSW-1:0]     wsum_less;

   logic signed [SW-1:0] bs_s, bh_s, mg_s, minh_s, last_s;
   logic signed [SW-1:0] ys0, ye0, fin1_ys, fin1_ye;
   logic signed [SW-1:0] fin2_ht, csum, center, ys2, fin2_ys;
   logic                 fin2_short;
   logic signed [SW-1:0] fin3_ye0, fin3_ye, fin3_ht;

   // store write from the front, two registered reads for the search
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= mem[raddr_a];
      rd_b_ff <= mem[raddr_b];
   end

   // window step: drop the top row while the rest still reaches the target
   assign wsum_less = wsum_ff - WSW'(rd_b_ff);
   assign shrink    = (top_ff < bottom_ff) && (CW'(wsum_less) >= CW'(target_ff));
   assign reach     = CW'(wsum_ff) >= CW'(target_ff);
   assign win_h     = bottom_ff - top_ff;

   assign raddr_a = {bank_ff, bottom_ff[RIW-1:0]};
   assign raddr_b = ((state_ff == S_SHR) && shrink) ? {bank_ff, RIW'(top_ff + RW'(1))}
                                                    : {bank_ff, top_ff[RIW-1:0]};

   // margin and minimum height products
   assign mg_prod = MG_W'(rows) * MG_W'(margin_ratio);
   assign d5_prod = D5_W'(rows) * D5_W'(DIV5_RECIP);
   assign fifth   = d5_prod[D5_W-1:DIV5_SHIFT];

   // band widening, clamping and re-centering
   assign bs_s   = $signed({3'b000, best_s_ff});
   assign bh_s   = $signed({3'b000, best_h_ff});
   assign mg_s   = $signed({3'b000, margin_ff});
   assign minh_s = $signed({3'b000, minh_ff});
   assign last_s = $signed({3'b000, rows}) - ONE_S;

   assign ys0     = bs_s - mg_s;
   assign ye0     = bs_s + bh_s + mg_s - ONE_S;
   assign fin1_ys = ys0[SW-1] ? ZERO_S : ys0;
   assign fin1_ye = (ye0 > last_s) ? last_s : ye0;

   assign fin2_ht    = ye_ff - ys_ff + ONE_S;
   assign fin2_short = fin2_ht < minh_s;
   assign csum       = ys_ff + ye_ff;
   assign center     = csum[SW-1] ? ZERO_S : (csum >>> 1);
   assign ys2        = center - (minh_s >>> 1);
   assign fin2_ys    = ys2[SW-1] ? ZERO_S : ys2;

   assign fin3_ye0 = ys_ff + minh_s - ONE_S;
   assign fin3_ye  = (fin3_ye0 > last_s) ? last_s : fin3_ye0;
   assign fin3_ht  = short_ff ? (fin3_ye - ys_ff + ONE_S) : ht_ff;

   // search sequencer
   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      tot_in        = tot_ff;
      p_hi_in       = p_hi_ff;
      p_lo_in       = p_lo_ff;
      margin_in     = margin_ff;
      minh_in       = minh_ff;
      target_in     = target_ff;
      wsum_in       = wsum_ff;
      top_in        = top_ff;
      bottom_in     = bottom_ff;
      best_h_in     = best_h_ff;
      best_s_in     = best_s_ff;
      ys_in         = ys_ff;
      ye_in         = ye_ff;
      ht_in         = ht_ff;
      short_in      = short_ff;
      res_start_in  = res_start_ff;
      res_height_in = res_height_ff;
      out_valid_in  = out_valid_ff && !pop;
      out_start_in  = out_start_ff;
      out_height_in = out_height_ff;
      job_pop       = 1'b0;
      rel.valid     = 1'b0;
      rel.bank      = bank_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               bank_in = job.bank;
               tot_in  = job.total;
               if (job.total == '0) begin
                  res_start_in  = START_W'(rows >> 2);
                  res_height_in = HEIGHT_W'(rows >> 1);
                  state_in      = S_DONE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            p_hi_in   = PH_W'(tot_ff[TOT_W-1:LO_W]) * PH_W'(energy_ratio);
            p_lo_in   = PL_W'(tot_ff[LO_W-1:0]) * PL_W'(energy_ratio);
            margin_in = mg_prod[MG_W-1:RATIO_W];
            minh_in   = (fifth == '0) ? RW'(1) : RW'(fifth);
            top_in    = '0;
            bottom_in = '0;
            wsum_in   = '0;
            best_h_in = rows;
            best_s_in = rows >> 2;
            state_in  = S_TGT;
         end
         S_TGT: begin
            // ceiling of total * ratio / 2^16 from the two partial products
            target_in = TOT_W'({p_hi_ff, 2'b00}) + TOT_W'(p_lo_ff[PL_W-1:FRAC_W])
                      + TOT_W'(|p_lo_ff[FRAC_W-1:0]);
            state_in  = S_ADD;
         end
         S_ADD: begin
            wsum_in   = wsum_ff + WSW'(rd_a_ff);
            bottom_in = bottom_ff + RW'(1);
            state_in  = S_SHR;
         end
         S_SHR: begin
            if (shrink) begin
               wsum_in = wsum_less;
               top_in  = top_ff + RW'(1);
            end else begin
               if (reach && (win_h < best_h_ff)) begin
                  best_h_in = win_h;
                  best_s_in = top_ff;
               end
               state_in = (bottom_ff < rows) ? S_ADD : S_FIN1;
            end
         end
         S_FIN1: begin
            ys_in    = fin1_ys;
            ye_in    = fin1_ye;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            ht_in    = fin2_ht;
            short_in = fin2_short;
            ys_in    = fin2_short ? fin2_ys : ys_ff;
            state_in = S_FIN3;
         end
         S_FIN3: begin
            res_start_in  = START_W'($unsigned(ys_ff));
            res_height_in = HEIGHT_W'($unsigned(fin3_ht));
            state_in      = S_DONE;
         end
         S_DONE: begin
            // load the result register and hand the bank back once it is empty or being popped
            if (!out_valid_ff || pop) begin
               out_valid_in  = 1'b1;
               out_start_in  = res_start_ff;
               out_height_in = res_height_ff;
               rel.valid     = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff       <= bank_in;
      tot_ff        <= tot_in;
      p_hi_ff       <= p_hi_in;
      p_lo_ff       <= p_lo_in;
      margin_ff     <= margin_in;
      minh_ff       <= minh_in;
      target_ff     <= target_in;
      wsum_ff       <= wsum_in;
      top_ff        <= top_in;
      bottom_ff     <= bottom_in;
      best_h_ff     <= best_h_in;
      best_s_ff     <= best_s_in;
      ys_ff         <= ys_in;
      ye_ff         <= ye_in;
      ht_ff         <= ht_in;
      short_ff      <= short_in;
      res_start_ff  <= res_start_in;
      res_height_ff <= res_height_in;
      out_start_ff  <= out_start_in;
      out_height_ff <= out_height_in;
   end

   assign empty       = !out_valid_ff;
   assign band_start  = out_start_ff;
   assign band_height = out_height_ff;

endmodule

`default_nettype wire
